// ----- hw/rtl/deq_pkg.sv -----
// Shared types and constants for the circular deque engine.
// Holds the opcode enum, the transfer payload structs and the cell control struct.
// No dependencies.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int CAP_W         = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index, taken from the word address bits of csr_paddr
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_DEL_FRONT = 3'd2,
      OP_DEL_REAR  = 3'd3,
      OP_QUERY     = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     success;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic              shift_back;   // every entry moves one place toward the rear
      logic              shift_fwd;    // every entry moves one place toward the front
      logic              write_rear;   // the cell at position count takes word
      logic [WORD_W-1:0] word;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/circular_deque_engine.sv -----
// Circular deque engine: bounded double-ended queue of signed 32-bit words.
// Input channel req_* carries an opcode and a value; result channel rsp_* returns one
// result per item: success, front and rear words (-1 when empty), empty and full flags,
// all after the operation. Both channels transfer on valid high and stall low.
// The entries sit in a row of DEPTH cells, front in cell 0; an insert or delete at the
// front shifts the whole row by one place, an insert at the rear writes the
// cell at the entry count. The rear word comes down a chain through the cells.
// The cell row and count take the item's update at the transfer in; the result is then
// formed from the updated row once the output register can take it, and registered.
// Throughput: one item per cycle while rsp_stall is low.
// One item waits behind the output register; while both are held, req_stall stays high.
// Capacity (register 0 at csr address 0) clamps to 1..DEPTH; write it only when idle.
// Reset (synchronous) empties the deque, sets capacity to 16 and drops any pending
// result. Slot contents are not cleared and are never observed.
module circular_deque_engine #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  deq_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output deq_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [deq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [deq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [deq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [deq_pkg::CAP_W-1:0]  cap_ff;
   logic [deq_pkg::CAP_W-1:0]  cap_in;
   logic [CNT_W-1:0]           cap_eff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       pend_ff;
   logic                       pend_in;
   logic                       pend_ok_ff;
   logic                       pend_ok_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   deq_pkg::rsp_type           rsp_data_ff;
   deq_pkg::rsp_type           rsp_data_in;
   deq_pkg::cell_ctrl_type     ctrl;
   logic                       accept;
   logic                       rsp_move;
   logic                       full_now;
   logic                       empty_now;
   logic                       ok;
   logic                       csr_write;

   logic [deq_pkg::WORD_W-1:0] cell_word [DEPTH];
   logic [deq_pkg::WORD_W-1:0] rear_link [DEPTH+1];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write && (csr_paddr[2] == deq_pkg::REG_CAPACITY)) begin
         cap_in = csr_pwdata[deq_pkg::CAP_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == deq_pkg::REG_CAPACITY) begin
         csr_prdata = deq_pkg::CSR_DATA_W'(cap_ff);
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // handshake
   assign rsp_move  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff && !rsp_move;
   assign accept    = req_valid && !req_stall;

   assign full_now  = (count_ff >= cap_eff);
   assign empty_now = (count_ff == '0);

   always_comb begin
      ctrl.shift_back = 1'b0;
      ctrl.shift_fwd  = 1'b0;
      ctrl.write_rear = 1'b0;
      ctrl.word       = req_data.value;
      count_in        = count_ff;
      ok              = 1'b0;
      case (req_data.opcode)
         deq_pkg::OP_INS_FRONT: begin
            ok = !full_now;
            ctrl.shift_back = accept && !full_now;
            if (accept && !full_now) count_in = count_ff + CNT_W'(1);
         end
         deq_pkg::OP_INS_REAR: begin
            ok = !full_now;
            ctrl.write_rear = accept && !full_now;
            if (accept && !full_now) count_in = count_ff + CNT_W'(1);
         end
         deq_pkg::OP_DEL_FRONT: begin
            ok = !empty_now;
            ctrl.shift_fwd = accept && !empty_now;
            if (accept && !empty_now) count_in = count_ff - CNT_W'(1);
         end
         deq_pkg::OP_DEL_REAR: begin
            ok = !empty_now;
            if (accept && !empty_now) count_in = count_ff - CNT_W'(1);
         end
         deq_pkg::OP_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // cell row; rear chain enters at the back as all ones so an empty deque reads -1
   assign rear_link[DEPTH] = '1;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [deq_pkg::WORD_W-1:0] prev_word;
      logic [deq_pkg::WORD_W-1:0] next_word;

      if (k == 0) begin : g_head
         assign prev_word = req_data.value;
      end else begin : g_body
         assign prev_word = cell_word[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign next_word = cell_word[k];
      end else begin : g_inner
         assign next_word = cell_word[k+1];
      end

      deq_cell #(
         .INDEX (k),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .prev_word (prev_word),
         .next_word (next_word),
         .rear_in   (rear_link[k+1]),
         .word_out  (cell_word[k]),
         .rear_out  (rear_link[k])
      );
   end

   // result formed from the row after the item's update
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff;
      if (rsp_move) begin
         rsp_valid_in           = pend_ff;
         rsp_data_in.success    = pend_ok_ff;
         rsp_data_in.is_empty   = empty_now;
         rsp_data_in.is_full    = full_now;
         rsp_data_in.front_word = empty_now ? '1 : cell_word[0];
         rsp_data_in.rear_word  = rear_link[0];
      end
      pend_in    = accept ? 1'b1 : (rsp_move ? 1'b0 : pend_ff);
      pend_ok_in = accept ? ok : pend_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= deq_pkg::CAP_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff  <= pend_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/deq_cell.sv -----
// One storage cell of the deque chain: holds the entry at a fixed position.
// Shifts with its neighbors and feeds the rear-word chain.
// Depends on deq_pkg.
module deq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  deq_pkg::cell_ctrl_type        ctrl,
   input  logic [CNT_W-1:0]              count,
   input  logic [deq_pkg::WORD_W-1:0]    prev_word,
   input  logic [deq_pkg::WORD_W-1:0]    next_word,
   input  logic [deq_pkg::WORD_W-1:0]    rear_in,
   output logic [deq_pkg::WORD_W-1:0]    word_out,
   output logic [deq_pkg::WORD_W-1:0]    rear_out
);

   logic [deq_pkg::WORD_W-1:0] word_ff;
   logic [deq_pkg::WORD_W-1:0] word_in;
   logic                       at_tail;
   logic                       is_rear;

   assign at_tail = (count == CNT_W'(INDEX));
   assign is_rear = (count == CNT_W'(INDEX + 1));

   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_back) begin
         word_in = prev_word;
      end else if (ctrl.shift_fwd) begin
         word_in = next_word;
      end else if (ctrl.write_rear && at_tail) begin
         word_in = ctrl.word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   // the rear entry replaces whatever arrives from further back
   assign rear_out = is_rear ? word_ff : rear_in;

endmodule
